// ===== hdl/ipu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared constants, codes and types of the integer pixel replication upscaler.
// ----------------------------------------------------------------------------
package ipu_pkg;

  localparam int MaxWidth = 2048;
  localparam int MaxScale = 64;
  localparam int PixW     = 24;
  localparam int ScaleW   = 7;
  localparam int RowW     = 12;
  localparam int CfgW     = 12;

  localparam logic       CmdPixel  = 1'b0;
  localparam logic       CmdReplay = 1'b1;

  localparam logic       RegScale  = 1'b0;
  localparam logic       RegWidth  = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusRefused = 2'd1;
  localparam logic [1:0] StatusEmpty   = 2'd2;

  // per-word control handed from the column logic to the emitter
  typedef struct packed {
    logic [1:0] status;
    logic       ends;
    logic [1:0] pad;
  } job_t;

endpackage

// ===== hdl/ipu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipu_ram
// Generic single-port synchronous RAM with registered read and read enable.
// ----------------------------------------------------------------------------
module ipu_ram #(
  parameter int Width = 24,
  parameter int Depth = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                       wdata_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/ipu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipu_ctrl
// Column and replay bookkeeping, line store access and the staged word that
// waits for the emitter.
// ----------------------------------------------------------------------------
module ipu_ctrl import ipu_pkg::*; #(
  parameter int MaxWidthP = MaxWidth,
  parameter int MaxScaleP = MaxScale,
  localparam int RW = (MaxScaleP > 1) ? $clog2(MaxScaleP) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ScaleW-1:0] scale_i,
  input  logic [RowW-1:0]   row_width_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              command_i,
  input  logic [PixW-1:0]   pix_i,
  output logic              job_valid_o,
  input  logic              job_take_i,
  output job_t              job_o,
  output logic [RW-1:0]     job_cnt_o,
  output logic [PixW-1:0]   job_pix_o
);

  localparam int CW = (MaxWidthP > 1) ? $clog2(MaxWidthP) : 1;
  localparam int WW = $clog2(MaxWidthP + 1);
  localparam int SW = $clog2(MaxScaleP + 1);
  localparam int EW = (WW > RowW) ? WW : RowW;
  localparam int XW = ((CW > WW) ? CW : WW) + 1;

  logic [CW-1:0]   wcol_q, wcol_d, rcol_q, rcol_d;
  logic [RW-1:0]   left_q, left_d;
  logic            s1_valid_q, s1_valid_d;
  job_t            s1_job_q, s1_job_d;
  logic [RW-1:0]   s1_cnt_q, s1_cnt_d;
  logic [PixW-1:0] s1_pix_q, s1_pix_d;
  logic            s1_rd_q, s1_rd_d;

  logic [SW-1:0]   sc_eff;
  logic [WW-1:0]   w_eff;
  logic [CW-1:0]   col;
  logic            ends;
  logic [1:0]      pad;
  logic            fire;
  logic            ram_we, ram_re;
  logic [PixW-1:0] ram_rdata;

  // clamp the registers to their useful range
  always_comb begin
    if (scale_i == '0) begin
      sc_eff = SW'(1);
    end else if (scale_i > ScaleW'(MaxScaleP)) begin
      sc_eff = SW'(MaxScaleP);
    end else begin
      sc_eff = SW'(scale_i);
    end
    if (row_width_i == '0) begin
      w_eff = WW'(1);
    end else if (EW'(row_width_i) > EW'(MaxWidthP)) begin
      w_eff = WW'(MaxWidthP);
    end else begin
      w_eff = WW'(row_width_i);
    end
  end

  assign in_ready_o = !s1_valid_q || job_take_i;
  assign fire       = in_valid_i && in_ready_o;
  assign col        = (command_i == CmdPixel) ? wcol_q : rcol_q;
  assign ends       = (XW'(col) + XW'(1)) >= XW'(w_eff);
  assign pad        = 2'(2'(w_eff) * 2'(sc_eff));

  always_comb begin
    wcol_d     = wcol_q;
    rcol_d     = rcol_q;
    left_d     = left_q;
    s1_valid_d = s1_valid_q;
    s1_job_d   = s1_job_q;
    s1_cnt_d   = s1_cnt_q;
    s1_pix_d   = s1_pix_q;
    s1_rd_d    = s1_rd_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (job_take_i) begin
      s1_valid_d = 1'b0;
    end
    if (fire) begin
      s1_valid_d      = 1'b1;
      s1_job_d.status = StatusOk;
      s1_job_d.ends   = ends;
      s1_job_d.pad    = ends ? pad : 2'd0;
      s1_cnt_d        = RW'(sc_eff - SW'(1));
      s1_pix_d        = pix_i;
      s1_rd_d         = 1'b0;
      if (command_i == CmdPixel) begin
        if (left_q != '0) begin
          s1_job_d = '{status: StatusRefused, ends: 1'b0, pad: 2'd0};
          s1_cnt_d = '0;
          s1_pix_d = '0;
        end else begin
          ram_we = 1'b1;
          if (ends) begin
            wcol_d = '0;
            rcol_d = '0;
            left_d = RW'(sc_eff - SW'(1));
          end else begin
            wcol_d = wcol_q + CW'(1);
          end
        end
      end else begin
        if (left_q == '0) begin
          s1_job_d = '{status: StatusEmpty, ends: 1'b0, pad: 2'd0};
          s1_cnt_d = '0;
          s1_pix_d = '0;
        end else begin
          ram_re  = 1'b1;
          s1_rd_d = 1'b1;
          if (ends) begin
            rcol_d = '0;
            left_d = left_q - RW'(1);
          end else begin
            rcol_d = rcol_q + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcol_q     <= '0;
      rcol_q     <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      wcol_q     <= wcol_d;
      rcol_q     <= rcol_d;
      left_q     <= left_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_job_q <= s1_job_d;
    s1_cnt_q <= s1_cnt_d;
    s1_pix_q <= s1_pix_d;
    s1_rd_q  <= s1_rd_d;
  end

  ipu_ram #(
    .Width (PixW),
    .Depth (MaxWidthP)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (col),
    .wdata_i (pix_i),
    .rdata_o (ram_rdata)
  );

  assign job_valid_o = s1_valid_q;
  assign job_o       = s1_job_q;
  assign job_cnt_o   = s1_cnt_q;
  assign job_pix_o   = s1_rd_q ? ram_rdata : s1_pix_q;

endmodule

// ===== hdl/ipu_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipu_emit
// Output register that repeats one staged word the requested number of times.
// ----------------------------------------------------------------------------
module ipu_emit import ipu_pkg::*; #(
  parameter int MaxScaleP = MaxScale,
  localparam int RW = (MaxScaleP > 1) ? $clog2(MaxScaleP) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_take_o,
  input  job_t            job_i,
  input  logic [RW-1:0]   job_cnt_i,
  input  logic [PixW-1:0] job_pix_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pix_o,
  output logic [1:0]      pad_bytes_o,
  output logic            row_end_o,
  output logic            last_o,
  output logic [1:0]      status_o
);

  logic            valid_q, valid_d;
  logic [RW-1:0]   left_q, left_d;
  job_t            job_q, job_d;
  logic [PixW-1:0] pix_q, pix_d;
  logic            done, free;

  assign done       = (left_q == '0);
  assign free       = !valid_q || (out_ready_i && done);
  assign job_take_o = free && job_valid_i;

  always_comb begin
    valid_d = valid_q;
    left_d  = left_q;
    job_d   = job_q;
    pix_d   = pix_q;
    if (job_take_o) begin
      valid_d = 1'b1;
      left_d  = job_cnt_i;
      job_d   = job_i;
      pix_d   = job_pix_i;
    end else if (valid_q && out_ready_i) begin
      if (done) begin
        valid_d = 1'b0;
      end else begin
        left_d = left_q - RW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      left_q  <= '0;
    end else begin
      valid_q <= valid_d;
      left_q  <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    pix_q <= pix_d;
  end

  assign out_valid_o = valid_q;
  assign pix_o       = pix_q;
  assign last_o      = done;
  assign row_end_o   = done && job_q.ends;
  assign pad_bytes_o = done ? job_q.pad : 2'd0;
  assign status_o    = job_q.status;

endmodule

// ===== hdl/integer_pixel_replication_upscaler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_pixel_replication_upscaler
// Nearest-neighbour upscaler for a 24-bit pixel stream by a whole factor.
//
// Input channel: one word per valid/ready handshake. command_i low carries a
// new pixel, which is stored in the line store and sent scale times; command
// high is a replay step that sends the next stored pixel scale times. After a
// full input row, scale-1 rows of replay steps are expected. A pixel during
// pending replays, or a replay with none pending, gives one word with status.
// Output channel: one pixel word per handshake; last_o marks the final word
// of an input word, row_end_o and pad_bytes_o the end of an output row.
// Configuration: cfg_we_i writes cfg_data_i to scale (index 0) or row_width
// (index 1) at once; write only while the block is idle.
// Path: the input word passes the staging register, then the output register.
// Each input word holds the single output register until its last repeat is
// taken, which bounds the sustained rate; scale is 1 to 64. Replays read the
// line store as the word enters the staging register.
// Reset clears columns, pending replays and registers (scale 1, width 1); the
// line store is not cleared. When the receiver stalls, the output word holds
// and one further input word is taken into the staging register.
// ----------------------------------------------------------------------------
module integer_pixel_replication_upscaler import ipu_pkg::*; #(
  parameter int MaxWidthP = MaxWidth,
  parameter int MaxScaleP = MaxScale
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            command_i,
  input  logic [7:0]      blue_i,
  input  logic [7:0]      green_i,
  input  logic [7:0]      red_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_blue_o,
  output logic [7:0]      out_green_o,
  output logic [7:0]      out_red_o,
  output logic [1:0]      pad_bytes_o,
  output logic            row_end_o,
  output logic            last_o,
  output logic [1:0]      status_o
);

  localparam int RW = (MaxScaleP > 1) ? $clog2(MaxScaleP) : 1;

  logic [ScaleW-1:0] scale_q;
  logic [RowW-1:0]   row_width_q;
  logic              job_valid, job_take;
  job_t              job;
  logic [RW-1:0]     job_cnt;
  logic [PixW-1:0]   job_pix, out_pix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= ScaleW'(1);
      row_width_q <= RowW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == RegScale) begin
        scale_q <= cfg_data_i[ScaleW-1:0];
      end else begin
        row_width_q <= cfg_data_i[RowW-1:0];
      end
    end
  end

  ipu_ctrl #(
    .MaxWidthP (MaxWidthP),
    .MaxScaleP (MaxScaleP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .row_width_i (row_width_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .pix_i       ({red_i, green_i, blue_i}),
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .job_o       (job),
    .job_cnt_o   (job_cnt),
    .job_pix_o   (job_pix)
  );

  ipu_emit #(
    .MaxScaleP (MaxScaleP)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .job_i       (job),
    .job_cnt_i   (job_cnt),
    .job_pix_i   (job_pix),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pix_o       (out_pix),
    .pad_bytes_o (pad_bytes_o),
    .row_end_o   (row_end_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

  assign out_blue_o  = out_pix[7:0];
  assign out_green_o = out_pix[15:8];
  assign out_red_o   = out_pix[23:16];

endmodule
